// ===== rtl/core/dlpg_pkg.sv =====
// Shared constants and control types for the DDA line pixel generator.
package dlpg_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int COORD_W = 12;
  localparam int COLOR_W = 32;
  localparam int INDEX_W = 20;

  // Integer part of a position: a coordinate difference needs one bit more.
  localparam int INT_W      = COORD_W + 1;
  localparam int POS_W      = INT_W + FRACTION_BITS;
  localparam int INC_W      = FRACTION_BITS + 2;
  localparam int QUO_W      = FRACTION_BITS + 1;
  localparam int REM_W      = COORD_W + 1;
  localparam int PTS_W      = COORD_W + 1;
  localparam int DIV_ITERS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic start;     // latch endpoints and set up the divide
    logic div_step;  // one quotient bit for both increments
    logic div_last;  // final quotient bit: write the increments
    logic emit;      // produce one point and advance the position
  } dlpg_cmd_t;

  typedef struct packed {
    logic line_active;
  } dlpg_status_t;

endpackage

// ===== rtl/core/dlpg_if.sv =====
// Valid/ready channel interfaces for items, points and the color register.
interface dlpg_item_if;
  import dlpg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dlpg_pixel_if;
  import dlpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [COLOR_W-1:0] pixel_value;
  logic               write_enable;
  logic               last_point;

  modport source (output valid, pixel_index, pixel_value, write_enable, last_point,
                  input ready);
  modport sink   (input valid, pixel_index, pixel_value, write_enable, last_point,
                  output ready);
endinterface

interface dlpg_cfg_if;
  import dlpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] line_color;

  modport source (output valid, line_color, input ready);
  modport sink   (input valid, line_color, output ready);
endinterface

// ===== rtl/core/dda_line_pixel_generator.sv =====
// Top level of the DDA line pixel generator: controller, datapath and channel wiring.
// Step transfer on an active line: its point appears in the output register the next cycle;
//   one step per cycle is sustained while the output side takes a point each cycle.
// Start transfer: gives no point and blocks items while the shared restoring divider forms
//   one quotient bit per cycle for both increments.
// Reset (rst, synchronous, active high): clear the line, the position, increments, the color
//   register and the output valid; the channel is ready in the cycle that reset drops.
module dda_line_pixel_generator
  import dlpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dlpg_cfg_if.sink    cfg,
  dlpg_item_if.sink   item,
  dlpg_pixel_if.source pixel
);

  dlpg_cmd_t    cmd;
  dlpg_status_t status;
  logic         item_ready;
  logic         out_valid;

  // The color register takes a write in any cycle out of reset.
  assign cfg.ready = !rst;

  // Sequence items: accept while idle and the output slot is free or draining,
  // run the divide after a start, and hold the point until its transfer.
  dlpg_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item.valid),
    .item_operation (item.operation),
    .pixel_ready    (pixel.ready),
    .status         (status),
    .item_ready     (item_ready),
    .out_valid      (out_valid),
    .cmd            (cmd)
  );

  // Hold line state, step the divider and register each point.
  dlpg_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .start_x        (item.start_x),
    .start_y        (item.start_y),
    .end_x          (item.end_x),
    .end_y          (item.end_y),
    .cfg_write      (cfg.valid),
    .cfg_line_color (cfg.line_color),
    .status         (status),
    .pixel_index    (pixel.pixel_index),
    .pixel_value    (pixel.pixel_value),
    .write_enable   (pixel.write_enable),
    .last_point     (pixel.last_point)
  );

  assign item.ready  = item_ready;
  assign pixel.valid = out_valid;

endmodule

// ===== rtl/core/dlpg_datapath.sv =====
// Datapath: endpoint setup, shared increment divider, position and point output.
module dlpg_datapath
  import dlpg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dlpg_cmd_t                 cmd,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic                      cfg_write,
  input  logic [COLOR_W-1:0]        cfg_line_color,
  output dlpg_status_t              status,
  output logic [INDEX_W-1:0]        pixel_index,
  output logic [COLOR_W-1:0]        pixel_value,
  output logic                      write_enable,
  output logic                      last_point
);

  localparam int PROD_W = 2 * INT_W;

  logic [COLOR_W-1:0]      line_color;
  logic                    line_active;
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic signed [INC_W-1:0] increment_x;
  logic signed [INC_W-1:0] increment_y;
  logic [PTS_W-1:0]        points_left;

  logic [REM_W-1:0]   rem_x;
  logic [REM_W-1:0]   rem_y;
  logic [QUO_W-1:0]   quo_x;
  logic [QUO_W-1:0]   quo_y;
  logic               neg_x;
  logic               neg_y;
  logic [COORD_W-1:0] divisor;

  // Setup
  logic signed [INT_W-1:0] dx;
  logic signed [INT_W-1:0] dy;
  logic [INT_W-1:0]        abs_dx;
  logic [INT_W-1:0]        abs_dy;
  logic [COORD_W-1:0]      steps;

  // Divider step
  logic             ge_x;
  logic             ge_y;
  logic [REM_W-1:0] rem_x_next;
  logic [REM_W-1:0] rem_y_next;
  logic [QUO_W-1:0] quo_x_next;
  logic [QUO_W-1:0] quo_y_next;
  logic [INC_W-1:0] inc_x_mag;
  logic [INC_W-1:0] inc_y_mag;

  // Point
  logic [INT_W-1:0]  px;
  logic [INT_W-1:0]  py;
  logic              in_window;
  logic [PROD_W-1:0] index_full;

  always_comb begin
    dx     = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
    dy     = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
    abs_dx = dx[INT_W-1] ? INT_W'(-dx) : INT_W'(dx);
    abs_dy = dy[INT_W-1] ? INT_W'(-dy) : INT_W'(dy);
    steps  = (abs_dx >= abs_dy) ? abs_dx[COORD_W-1:0] : abs_dy[COORD_W-1:0];
  end

  // Restoring divide, one bit per cycle; remainder stays below twice the divisor.
  always_comb begin
    ge_x       = rem_x >= {1'b0, divisor};
    ge_y       = rem_y >= {1'b0, divisor};
    rem_x_next = ge_x ? REM_W'((rem_x - {1'b0, divisor}) << 1) : REM_W'(rem_x << 1);
    rem_y_next = ge_y ? REM_W'((rem_y - {1'b0, divisor}) << 1) : REM_W'(rem_y << 1);
    quo_x_next = {quo_x[QUO_W-2:0], ge_x};
    quo_y_next = {quo_y[QUO_W-2:0], ge_y};
    inc_x_mag  = INC_W'(quo_x_next);
    inc_y_mag  = INC_W'(quo_y_next);
  end

  // Truncate the position toward zero and build the framebuffer index.
  always_comb begin
    px = position_x[POS_W-1 -: INT_W]
         + INT_W'(position_x[POS_W-1] && (|position_x[FRACTION_BITS-1:0]));
    py = position_y[POS_W-1 -: INT_W]
         + INT_W'(position_y[POS_W-1] && (|position_y[FRACTION_BITS-1:0]));
    in_window = !px[INT_W-1] && (px < INT_W'(SCREEN_WIDTH))
             && !py[INT_W-1] && (py < INT_W'(SCREEN_HEIGHT));
    index_full = PROD_W'(py) * PROD_W'(SCREEN_WIDTH) + PROD_W'(px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_color  <= '0;
      line_active <= 1'b0;
      position_x  <= '0;
      position_y  <= '0;
      increment_x <= '0;
      increment_y <= '0;
      points_left <= '0;
    end else begin
      if (cfg_write) begin
        line_color <= cfg_line_color;
      end
      if (cmd.start) begin
        position_x  <= {{(INT_W-COORD_W){start_x[COORD_W-1]}}, start_x,
                        {FRACTION_BITS{1'b0}}};
        position_y  <= {{(INT_W-COORD_W){start_y[COORD_W-1]}}, start_y,
                        {FRACTION_BITS{1'b0}}};
        points_left <= PTS_W'(steps) + PTS_W'(1);
        line_active <= 1'b1;
      end else if (cmd.emit) begin
        position_x <= position_x + {{(POS_W-INC_W){increment_x[INC_W-1]}}, increment_x};
        position_y <= position_y + {{(POS_W-INC_W){increment_y[INC_W-1]}}, increment_y};
        if (points_left <= PTS_W'(1)) begin
          points_left <= '0;
          line_active <= 1'b0;
        end else begin
          points_left <= points_left - PTS_W'(1);
        end
      end
      if (cmd.div_last) begin
        // Zero-length line: drop the quotient of the divide by zero.
        if (divisor == '0) begin
          increment_x <= '0;
          increment_y <= '0;
        end else begin
          increment_x <= neg_x ? INC_W'(-inc_x_mag) : inc_x_mag;
          increment_y <= neg_y ? INC_W'(-inc_y_mag) : inc_y_mag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_x   <= REM_W'(abs_dx);
      rem_y   <= REM_W'(abs_dy);
      quo_x   <= '0;
      quo_y   <= '0;
      neg_x   <= dx[INT_W-1];
      neg_y   <= dy[INT_W-1];
      divisor <= steps;
    end else if (cmd.div_step) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
    end
    if (cmd.emit) begin
      pixel_index  <= in_window ? index_full[INDEX_W-1:0] : '0;
      pixel_value  <= line_color;
      write_enable <= in_window;
      last_point   <= points_left <= PTS_W'(1);
    end
  end

  assign status.line_active = line_active;

endmodule

// ===== rtl/core/dlpg_ctrl.sv =====
// Controller: item acceptance, divide sequencing and output register valid.
module dlpg_ctrl
  import dlpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_operation,
  input  logic         pixel_ready,
  input  dlpg_status_t status,
  output logic         item_ready,
  output logic         out_valid,
  output dlpg_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;
  logic                 out_valid_next;
  logic                 item_fire;
  logic                 cnt_last;

  assign item_ready = !rst && (state == ST_IDLE) && (!out_valid || pixel_ready);
  assign item_fire  = item_valid && item_ready;
  assign cnt_last   = div_cnt == DIV_CNT_W'(DIV_ITERS - 1);

  always_comb begin
    cmd.start    = item_fire && (item_operation == OP_START);
    cmd.emit     = item_fire && (item_operation == OP_STEP) && status.line_active;
    cmd.div_step = state == ST_DIV;
    cmd.div_last = (state == ST_DIV) && cnt_last;
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next   = ST_DIV;
          div_cnt_next = '0;
        end
      end
      ST_DIV: begin
        if (cnt_last) begin
          state_next   = ST_IDLE;
          div_cnt_next = '0;
        end else begin
          div_cnt_next = div_cnt + DIV_CNT_W'(1);
        end
      end
      default: begin
        state_next   = ST_IDLE;
        div_cnt_next = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (pixel_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cmd.start |=> (state == ST_DIV))
    else $error("start transfer did not enter divide");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.start |=> ##(DIV_ITERS) (state == ST_IDLE))
    else $error("divide did not finish after the expected iteration count");
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> (div_cnt == '0))
    else $error("divide counter not cleared while idle");
  assert property (@(posedge clk) disable iff (rst) (cmd.emit && out_valid) |-> pixel_ready)
    else $error("point overwrote a result that was not taken");
`endif

endmodule
